### rtl/b64enc_pkg.sv
// b64enc_pkg: types, constants and the character lookup for the base64 stream encoder
// depends on nothing; imported by every module of the encoder
package b64enc_pkg;

   localparam int B64ENC_FIFO_DEPTH = 2;

   localparam logic [6:0] CHAR_UPPER_A = 7'h41;
   localparam logic [6:0] CHAR_LOWER_A = 7'h61;
   localparam logic [6:0] CHAR_DIGIT_0 = 7'h30;
   localparam logic [6:0] CHAR_PLUS    = 7'h2B;
   localparam logic [6:0] CHAR_SLASH   = 7'h2F;
   localparam logic [6:0] CHAR_PAD     = 7'h3D;

   localparam logic [5:0] SYM_LOWER_START = 6'd26;
   localparam logic [5:0] SYM_DIGIT_START = 6'd52;
   localparam logic [5:0] SYM_PLUS        = 6'd62;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } b64enc_req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_char;
   } b64enc_rsp_type;

   // bytes already taken from the current three-byte group
   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } b64enc_phase_type;

   // one classified byte: up to four characters, index of the final one
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            eom;
   } b64enc_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } b64enc_fifo_status_type;

   // six-bit code to standard alphabet character
   function automatic logic [6:0] b64_sym(input logic [5:0] v);
      logic [6:0] v7;
      v7 = {1'b0, v};
      priority if (v < SYM_LOWER_START) begin
         return CHAR_UPPER_A + v7;
      end else if (v < SYM_DIGIT_START) begin
         return CHAR_LOWER_A + v7 - {1'b0, SYM_LOWER_START};
      end else if (v < SYM_PLUS) begin
         return CHAR_DIGIT_0 + v7 - {1'b0, SYM_DIGIT_START};
      end else if (v == SYM_PLUS) begin
         return CHAR_PLUS;
      end else begin
         return CHAR_SLASH;
      end
   endfunction

endpackage

### rtl/b64enc_front.sv
// b64enc_front: group phase tracking and byte classification into character entries
// depends on b64enc_pkg
module b64enc_front
   import b64enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64enc_req_type   req_data,
   output b64enc_entry_type entry
);

   b64enc_phase_type phase_ff, phase_in;
   logic [3:0]       left_ff, left_in;

   logic [7:0] b;
   logic       eom;

   assign b   = req_data.data_byte;
   assign eom = req_data.end_of_message;

   // next state
   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      if (push) begin
         unique case (phase_ff)
            PHASE_1: begin
               phase_in = eom ? PHASE_0 : PHASE_2;
               left_in  = eom ? 4'd0 : b[3:0];
            end
            PHASE_2: begin
               phase_in = PHASE_0;
               left_in  = 4'd0;
            end
            default: begin
               phase_in = eom ? PHASE_0 : PHASE_1;
               left_in  = eom ? 4'd0 : {2'b00, b[1:0]};
            end
         endcase
      end
   end

   // outputs: the characters this byte completes
   always_comb begin
      entry.chars    = {4{CHAR_PAD}};
      entry.last_idx = 2'd0;
      entry.eom      = eom;
      unique case (phase_ff)
         PHASE_1: begin
            entry.chars[0] = b64_sym({left_ff[1:0], b[7:4]});
            if (eom) begin
               entry.chars[1] = b64_sym({b[3:0], 2'b00});
               entry.last_idx = 2'd2;
            end
         end
         PHASE_2: begin
            entry.chars[0] = b64_sym({left_ff, b[7:6]});
            entry.chars[1] = b64_sym(b[5:0]);
            entry.last_idx = 2'd1;
         end
         default: begin
            entry.chars[0] = b64_sym(b[7:2]);
            if (eom) begin
               entry.chars[1] = b64_sym({b[1:0], 4'b0000});
               entry.last_idx = 2'd3;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         left_ff  <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   // leftover bits are clear at the start of every group
   a_group_start_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_0) |-> (left_ff == 4'd0))
      else $error("leftover bits set at group start");

endmodule

### rtl/b64enc_fifo.sv
// b64enc_fifo: short entry queue between the classifier and the serializer
// depends on b64enc_pkg
module b64enc_fifo
   import b64enc_pkg::*;
#(
   parameter int FIFO_DEPTH = B64ENC_FIFO_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  b64enc_entry_type       push_entry,
   input  logic                   pop,
   output b64enc_entry_type       head,
   output b64enc_fifo_status_type status
);

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

   b64enc_entry_type entry_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_FULL);
   assign status.empty = (count_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue underflow");

endmodule

### rtl/b64enc_back.sv
// b64enc_back: serializes queued entries into one character per transaction
// depends on b64enc_pkg
module b64enc_back
   import b64enc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  b64enc_entry_type       head,
   input  b64enc_fifo_status_type fifo_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output b64enc_rsp_type         rsp_data
);

   logic           rsp_valid_ff, rsp_valid_in;
   b64enc_rsp_type rsp_ff, rsp_in;
   logic [1:0]     idx_ff, idx_in;
   logic           load;
   logic           at_last;

   assign load    = (!rsp_valid_ff || rsp_ready) && !fifo_status.empty;
   assign at_last = (idx_ff == head.last_idx);
   assign pop     = load && at_last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      idx_in       = idx_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_char    = head.chars[idx_ff];
         rsp_in.last_char   = head.eom && at_last;
         idx_in             = at_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !fifo_status.empty |-> (idx_ff <= head.last_idx))
      else $error("character index past end of entry");

endmodule

### rtl/base64_stream_encoder.sv
// base64_stream_encoder: top level of the streaming base64 encoder
// depends on b64enc_pkg, b64enc_front, b64enc_fifo, b64enc_back
//
// One raw byte enters per req transaction, flagged end_of_message on the last
// byte of a message; standard alphabet characters (A-Z a-z 0-9 + /, '=' pad)
// leave one per rsp transaction, last_char marking the final one of a message.
// A byte yields one character in the first and second positions of a group,
// two in the third, and a final byte closing a short group yields three or
// four including padding. The output register sends at most one character per
// cycle, so that port sets the sustained rate, with four characters for every
// three bytes within a message. Bytes are taken every cycle while the
// FIFO_DEPTH entry queue has room, independent of rsp stalls; the first
// character of a byte passes through the entry queue and then the output
// register. No clearing pass is needed after reset.
module base64_stream_encoder
   import b64enc_pkg::*;
#(
   parameter int FIFO_DEPTH = B64ENC_FIFO_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  b64enc_req_type req_data,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output b64enc_rsp_type rsp_data
);

   b64enc_entry_type       front_entry;
   b64enc_entry_type       fifo_head;
   b64enc_fifo_status_type fifo_status;
   logic                   fifo_push;
   logic                   fifo_pop;

   // front side only waits for queue room
   assign req_ready = !fifo_status.full;
   assign fifo_push = req_valid && req_ready;

   // classify each byte against the current group phase
   b64enc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (fifo_push),
      .req_data (req_data),
      .entry    (front_entry)
   );

   // decouples byte intake from character output
   b64enc_fifo #(
      .FIFO_DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (fifo_push),
      .push_entry (front_entry),
      .pop        (fifo_pop),
      .head       (fifo_head),
      .status     (fifo_status)
   );

   // one character per rsp transaction
   b64enc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (fifo_head),
      .fifo_status (fifo_status),
      .pop         (fifo_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

### verif/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// base64_stream_encoder_tb: self-checking testbench for the base64 stream encoder
// depends on b64enc_pkg and base64_stream_encoder; predicts every character in a local queue

module base64_stream_encoder_tb;
   import b64enc_pkg::*;

   localparam int HOLD_CYCLES  = 200;       // long output stall to fill the encoder
   localparam int DRAIN_CYCLES = 20;        // quiet time after the last character
   localparam int RUN_LIMIT_NS = 2_000_000; // overall run limit in ns

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   b64enc_req_type req_data = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   b64enc_rsp_type rsp_data;

   // encoder state as the predictor sees it
   b64enc_phase_type enc_phase = PHASE_0;
   logic [3:0]       enc_leftover = '0;

   // characters still owed by the encoder, oldest first
   b64enc_rsp_type expected_chars[$];
   b64enc_rsp_type want_char;
   int             mismatch_count = 0;

   // idle rates in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // output stall control: bumping hold_trigger starts one long stall
   int hold_trigger = 0;
   int hold_seen = 0;
   int hold_count = 0;

   base64_stream_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------

   // six-bit code to its alphabet character
   function automatic logic [6:0] sextet_char(input logic [5:0] code);
      logic [0:63][7:0] alphabet;
      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return alphabet[code][6:0];
   endfunction

   function automatic void push_char(input logic [6:0] ch, input logic last);
      b64enc_rsp_type entry;
      entry.out_char  = ch;
      entry.last_char = last;
      expected_chars.insert(expected_chars.size(), entry);
   endfunction

   // characters that one accepted byte completes, and the next state
   function automatic void predict_chars(input logic [7:0] data, input logic eom);
      case (enc_phase)
         PHASE_1: begin
            // two leftover bits from the first byte, top nibble of this one
            push_char(sextet_char({enc_leftover[1:0], data[7:4]}), 1'b0);
            if (eom) begin
               push_char(sextet_char({data[3:0], 2'b00}), 1'b0);
               push_char(CHAR_PAD, 1'b1);
               enc_phase    = PHASE_0;
               enc_leftover = '0;
            end else begin
               enc_leftover = data[3:0];
               enc_phase    = PHASE_2;
            end
         end
         PHASE_2: begin
            // group complete: two characters whether or not the message ends
            push_char(sextet_char({enc_leftover, data[7:6]}), 1'b0);
            push_char(sextet_char(data[5:0]), eom);
            enc_phase    = PHASE_0;
            enc_leftover = '0;
         end
         default: begin
            // start of a group; a lone final byte gets two pad characters
            push_char(sextet_char(data[7:2]), 1'b0);
            if (eom) begin
               push_char(sextet_char({data[1:0], 4'b0000}), 1'b0);
               push_char(CHAR_PAD, 1'b0);
               push_char(CHAR_PAD, 1'b1);
               enc_phase    = PHASE_0;
               enc_leftover = '0;
            end else begin
               enc_leftover = {2'b00, data[1:0]};
               enc_phase    = PHASE_1;
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------

   // offer one byte, hold it until the req transaction, then predict its output.
   // ready is sampled at the falling edge, where it is settled for the next rising edge
   task automatic send_byte(input logic [7:0] data, input logic eom);
      b64enc_req_type item;
      logic           taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.data_byte      = data;
      item.end_of_message = eom;
      req_valid <= 1'b1;
      req_data  <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      predict_chars(data, eom);
   endtask

   // one message of random bytes, end_of_message on the last
   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(255)), i == len - 1);
      end
   endtask

   // sender stays quiet until every owed character has come out
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // output side
   // ------------------------------------------------------------------

   // receiver: random idling, or a counted long stall when triggered
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_count <= 0;
         hold_seen  <= 0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_count <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // checker: a transaction seen at the falling edge completes at the next rising edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_chars.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected transaction, expected none, got char %h last %b",
                     $time, rsp_data.out_char, rsp_data.last_char);
         end else begin
            want_char = expected_chars.pop_front();
            if (want_char.out_char !== rsp_data.out_char ||
                want_char.last_char !== rsp_data.last_char) begin
               mismatch_count++;
               $display("%0t: mismatch, expected char %h last %b, got char %h last %b",
                        $time, want_char.out_char, want_char.last_char,
                        rsp_data.out_char, rsp_data.last_char);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // short messages of every length class, extreme bytes, alphabet corners
   task automatic test_directed_messages();
      send_byte(8'h00, 1'b1);                     // lone byte, two pads
      send_byte(8'hFF, 1'b0);                     // two bytes, one pad
      send_byte(8'hFF, 1'b1);
      send_byte(8'h4D, 1'b0);                     // plain full group
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b1);
      send_byte(8'hFB, 1'b0);                     // all '+' characters
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      send_byte(8'hFF, 1'b0);                     // all '/' characters
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);                     // group plus a short tail
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h03, 1'b0);                     // set low bits, then a fresh
      send_byte(8'hF0, 1'b1);                     // message must start clean
      send_byte(8'h00, 1'b1);
   endtask

   // mostly short messages, now and then a long one
   task automatic test_random_messages(input int byte_target);
      int sent;
      int len;
      sent = 0;
      while (sent < byte_target) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 6);
         send_message(len);
         sent += len;
      end
   endtask

   // output stalled for a long stretch while bytes keep coming, so input backs up
   task automatic test_output_stall();
      hold_trigger <= hold_trigger + 1;
      for (int m = 0; m < 3; m++) begin
         send_message(8);
      end
      wait_for_drain();
   endtask

   // sender goes quiet mid-group until the encoder is empty, then finishes the message
   task automatic test_sender_pause();
      send_byte(8'($urandom_range(255)), 1'b0);
      wait_for_drain();
      send_byte(8'($urandom_range(255)), 1'b0);
      wait_for_drain();
      send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(8'($urandom_range(255)), 1'b1);
      wait_for_drain();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // slow sender, very slow receiver
      send_idle_pct = 30;
      recv_idle_pct <= 86;
      test_directed_messages();
      test_random_messages(85);

      // very slow sender, slow receiver
      send_idle_pct = 86;
      recv_idle_pct <= 30;
      test_random_messages(85);

      // both sides at full rate
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      test_random_messages(60);
      test_output_stall();
      test_sender_pause();

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_chars.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // run limit
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
